[rtl/core/psmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair-sum match counter package
// Table sizes, derived widths and the sequencer state type.
// ----------------------------------------------------------------------------
package psmc_pkg;

	// Table geometry and count width.
	localparam int TABLE_ENTRIES = 64;
	localparam int COUNT_BITS    = 16;

	// Derived widths: an entry index, and a fill level that can hold the depth itself.
	localparam int IDX_BITS  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int FILL_BITS = $clog2(TABLE_ENTRIES + 1);

	localparam logic [FILL_BITS-1:0]  FILL_MAX  = FILL_BITS'(TABLE_ENTRIES);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Item commands.
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_PROBE = 1'b1;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_DONE
	} state_t;

endpackage

[rtl/core/pair_sum_match_counter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair-sum match counter
// Builds a table of distinct keys with occurrence counts and, for each probe,
// adds the count of key (target_sum - value) to a saturating running total.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  -------   ---------  ----------------------  ------------------------------
//  input     in         in_valid / in_ready     cmd, value
//  result    out        out_valid / out_ready   pair_total, table_overflow
//  config    in         cfg_wr_en (no wait)     cfg_wr_data -> target_sum
//
// After the input transfer, the N filled entries are compared one per cycle;
// the scan stops at a hit, else covers all keys held. An update step and
// then a result step, which loads the output register, follow. An empty table
// skips the scan; a probe with an out-of-range difference skips both. Reset
// clears the fill level, the total and the flag. A new item is taken only
// after the result is loaded, and a busy output register holds the input off.

module pair_sum_match_counter_top
	import psmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic signed [31:0] value,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] pair_total,
	output logic        table_overflow
);

	// Sequencer state and control.
	state_t state_q, state_d;

	logic [31:0]            target_q;
	logic                   cmd_q;
	logic [31:0]            key_q;
	logic [FILL_BITS-1:0]   fill_q;
	logic [FILL_BITS-1:0]   scan_idx_q;
	logic                   hit_q;
	logic [IDX_BITS-1:0]    hit_idx_q;
	logic [COUNT_BITS-1:0]  hit_cnt_q;
	logic [31:0]            total_q;
	logic                   overflow_q;
	logic                   out_valid_q;
	logic [31:0]            out_total_q;
	logic                   out_overflow_q;

	// Compare stage after the registered memory read.
	logic                   cmp_valid_s1;
	logic                   cmp_last_s1;
	logic [IDX_BITS-1:0]    cmp_idx_s1;
	logic [31:0]            rd_key_s1;
	logic [COUNT_BITS-1:0]  rd_cnt_s1;

	// Table memories.
	logic [31:0]           key_mem [TABLE_ENTRIES];
	logic [COUNT_BITS-1:0] cnt_mem [TABLE_ENTRIES];

	logic                  accept;
	logic                  issue_en;
	logic                  upd_en;
	logic                  out_load;
	logic                  match;
	logic [32:0]           diff;
	logic                  diff_in_range;
	logic [31:0]           lookup_key;
	logic                  key_we;
	logic                  cnt_we;
	logic [IDX_BITS-1:0]   wr_idx;
	logic [COUNT_BITS-1:0] cnt_wr_data;
	logic [32:0]           total_sum;
	logic [31:0]           total_next;

	// Lookup key: a load uses the value, a probe uses target - value in 33 bits.
	assign diff = {target_q[31], target_q} - {value[31], value};
	assign diff_in_range = (diff[32] == diff[31]);
	assign lookup_key = (cmd == CMD_PROBE) ? diff[31:0] : value;

	assign match = cmp_valid_s1 && (rd_key_s1 == key_q);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if ((cmd == CMD_PROBE) && !diff_in_range) begin
						state_d = ST_DONE;
					end else if (fill_q == '0) begin
						state_d = ST_UPDATE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (match || (cmp_valid_s1 && cmp_last_s1)) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		issue_en = (state_q == ST_SCAN) && (scan_idx_q < fill_q) && !match;
		upd_en   = (state_q == ST_UPDATE);
		out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	assign accept = in_valid && in_ready;

	// Table write decisions for the update step.
	always_comb begin
		key_we      = 1'b0;
		cnt_we      = 1'b0;
		wr_idx      = fill_q[IDX_BITS-1:0];
		cnt_wr_data = COUNT_BITS'(1);
		if (upd_en && (cmd_q == CMD_LOAD)) begin
			if (hit_q) begin
				cnt_we = 1'b1;
				wr_idx = hit_idx_q;
				cnt_wr_data = (hit_cnt_q == COUNT_MAX) ? hit_cnt_q
				                                        : hit_cnt_q + 1'b1;
			end else if (fill_q != FILL_MAX) begin
				key_we = 1'b1;
				cnt_we = 1'b1;
			end
		end
	end

	// Saturating add of the matched count to the total.
	assign total_sum  = {1'b0, total_q} + {{(33 - COUNT_BITS){1'b0}}, hit_cnt_q};
	assign total_next = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_wr_en) begin
			target_q <= cfg_wr_data;
		end
	end

	// Item payload captured at the input transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			key_q <= lookup_key;
		end
	end

	// Scan pointer and compare-stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q   <= '0;
			cmp_valid_s1 <= 1'b0;
			cmp_last_s1  <= 1'b0;
			cmp_idx_s1   <= '0;
		end else begin
			cmp_valid_s1 <= issue_en;
			if (accept) begin
				scan_idx_q <= '0;
			end else if (issue_en) begin
				scan_idx_q  <= scan_idx_q + 1'b1;
				cmp_idx_s1  <= scan_idx_q[IDX_BITS-1:0];
				cmp_last_s1 <= (FILL_BITS'(scan_idx_q + 1'b1) == fill_q);
			end
		end
	end

	// Hit capture during the scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q     <= 1'b0;
			hit_idx_q <= '0;
			hit_cnt_q <= '0;
		end else if (accept) begin
			hit_q <= 1'b0;
		end else if ((state_q == ST_SCAN) && match) begin
			hit_q     <= 1'b1;
			hit_idx_q <= cmp_idx_s1;
			hit_cnt_q <= rd_cnt_s1;
		end
	end

	// Fill level, running total and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			total_q    <= '0;
			overflow_q <= 1'b0;
		end else if (upd_en) begin
			if (cmd_q == CMD_LOAD) begin
				if (!hit_q) begin
					if (fill_q != FILL_MAX) begin
						fill_q <= fill_q + 1'b1;
					end else begin
						overflow_q <= 1'b1;
					end
				end
			end else if (hit_q) begin
				total_q <= total_next;
			end
		end
	end

	// Key memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wr_idx] <= key_q;
		end
		if (issue_en) begin
			rd_key_s1 <= key_mem[scan_idx_q[IDX_BITS-1:0]];
		end
	end

	// Count memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[wr_idx] <= cnt_wr_data;
		end
		if (issue_en) begin
			rd_cnt_s1 <= cnt_mem[scan_idx_q[IDX_BITS-1:0]];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_total_q    <= total_q;
			out_overflow_q <= overflow_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign pair_total     = out_total_q;
	assign table_overflow = out_overflow_q;

	// The fill level never exceeds the table depth.
	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= FILL_MAX)
		else $error("fill level beyond table depth");

	// Once raised, the overflow flag stays set.
	assert property (@(posedge clk) disable iff (!arst_n) overflow_q |=> overflow_q)
		else $error("overflow flag cleared");

	// The running total never decreases.
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (total_q >= $past(total_q)))
		else $error("running total decreased");

	// A compared entry always lies inside the filled part of the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmp_valid_s1 |-> ({1'b0, cmp_idx_s1} < {1'b0, fill_q}))
		else $error("compare of an unfilled entry");

	// The result step is not left while the output register is busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && out_valid_q && !out_ready |=> (state_q == ST_DONE))
		else $error("result step left while output register busy");

endmodule
